// ===== src/nmeafx_pkg.sv =====
`default_nettype none

package nmeafx_pkg;

    // ASCII characters that steer the parser
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_A      = 8'h41;

    // field codes on the output
    localparam logic [3:0] FC_TIME   = 4'd0;
    localparam logic [3:0] FC_DATE   = 4'd8;
    localparam logic [3:0] FC_ALT    = 4'd9;

    // GGA altitude sits after the eighth comma
    localparam logic [3:0] GGA_ALT_COMMA = 4'd8;
    localparam logic [3:0] COMMA_MAX     = 4'd15;

    typedef struct packed {
        logic       valid;
        logic [3:0] field_code;
        logic [3:0] char_pos;
        logic [7:0] char_value;
        logic       sentence_end;
    } t_result;

endpackage

`default_nettype wire

// ===== src/nmea_rmc_gga_field_extractor.sv =====
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+--------------------------------------------
// in      | input     | i_in_valid / o_in_stall  | i_rx_byte[7:0]
// out     | output    | o_out_valid / i_out_stall | o_field_code, o_char_pos, o_char_value,
//         |           |                        | o_sentence_end
//
// One byte per cycle sustained while no result beat is held under i_out_stall; a result beat
// leaves through the input register, then parser logic into the result register.
// Bytes that make no result (header, commas, unkept fields) just update parser state.
// Reset (i_rst_n low, synchronous) empties both registers and returns to waiting for '$'.
// The pipeline moves as one: it halts only while a result beat is held under i_out_stall.
`default_nettype none

module nmea_rmc_gga_field_extractor
    import nmeafx_pkg::*;
#(
    parameter int MAX_FIELD_LEN = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [3:0]      o_field_code,
    output logic [3:0]      o_char_pos,
    output logic [7:0]      o_char_value,
    output logic            o_sentence_end
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_valid;
    logic [3:0] r_field_code;
    logic [3:0] r_char_pos;
    logic [7:0] r_char_value;
    logic       r_sentence_end;

    logic    advance;
    t_result res;

    // everything shifts unless a held result is blocked downstream
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;

    nmeafx_parse #(
        .MAX_FIELD_LEN(MAX_FIELD_LEN)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (advance && r_in_valid),
        .i_byte (r_in_byte),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid  <= i_in_valid;
            r_out_valid <= res.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_byte      <= i_rx_byte;
            r_field_code   <= res.field_code;
            r_char_pos     <= res.char_pos;
            r_char_value   <= res.char_value;
            r_sentence_end <= res.sentence_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_field_code   = r_field_code;
    assign o_char_pos     = r_char_pos;
    assign o_char_value   = r_char_value;
    assign o_sentence_end = r_sentence_end;

endmodule

`default_nettype wire

// ===== src/nmeafx_parse.sv =====
`default_nettype none

// Sentence parser: header match, comma count and field position.
// State advances on i_step; o_res is the result for the current byte.
module nmeafx_parse
    import nmeafx_pkg::*;
#(
    parameter int MAX_FIELD_LEN = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_result         o_res
);

    localparam int PW = $clog2(MAX_FIELD_LEN + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FIELD_LEN);

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RMC  = 2'd1;
    localparam logic [1:0] KIND_GGA  = 2'd2;

    typedef enum logic [2:0] {
        HDR_WAIT,
        HDR_DOLLAR,
        HDR_G,
        HDR_P,
        HDR_K3,
        HDR_K4,
        HDR_K5,
        HDR_BODY
    } t_hdr;

    t_hdr          r_hdr,   n_hdr;
    logic [1:0]    r_kind,  n_kind;
    logic [3:0]    r_comma, n_comma;
    logic [PW-1:0] r_pos,   n_pos;

    t_result    res;
    logic       ok;
    logic       kept;
    logic [3:0] code;

    // field code of the current field
    always_comb begin
        kept = 1'b0;
        code = FC_TIME;
        if (r_kind == KIND_RMC && r_comma <= FC_DATE) begin
            kept = 1'b1;
            code = r_comma;
        end else if (r_kind == KIND_GGA && r_comma == GGA_ALT_COMMA) begin
            kept = 1'b1;
            code = FC_ALT;
        end
    end

    always_comb begin
        n_hdr   = r_hdr;
        n_kind  = r_kind;
        n_comma = r_comma;
        n_pos   = r_pos;
        ok      = 1'b0;
        res     = '0;

        if (i_byte == CH_DOLLAR) begin
            n_hdr   = HDR_DOLLAR;
            n_kind  = KIND_NONE;
            n_comma = '0;
            n_pos   = '0;
        end else if (r_hdr != HDR_BODY) begin
            case (r_hdr)
                HDR_DOLLAR: ok = (i_byte == CH_G);
                HDR_G:      ok = (i_byte == CH_P);
                HDR_P: begin
                    if (i_byte == CH_R) begin
                        n_kind = KIND_RMC;
                        ok     = 1'b1;
                    end else if (i_byte == CH_G) begin
                        n_kind = KIND_GGA;
                        ok     = 1'b1;
                    end
                end
                HDR_K3: ok = (r_kind == KIND_RMC) ? (i_byte == CH_M) : (i_byte == CH_G);
                HDR_K4: ok = (r_kind == KIND_RMC) ? (i_byte == CH_C) : (i_byte == CH_A);
                HDR_K5: ok = (i_byte == CH_COMMA);
                default: ok = 1'b0;
            endcase
            n_comma = '0;
            n_pos   = '0;
            if (ok) begin
                n_hdr = t_hdr'(r_hdr + 3'd1);
            end else begin
                n_hdr  = HDR_WAIT;
                n_kind = KIND_NONE;
            end
        end else if (i_byte == CH_STAR) begin
            n_hdr            = HDR_WAIT;
            n_kind           = KIND_NONE;
            n_comma          = '0;
            n_pos            = '0;
            res.valid        = i_step;
            res.sentence_end = 1'b1;
        end else if (i_byte == CH_COMMA) begin
            if (r_comma != COMMA_MAX) begin
                n_comma = r_comma + 4'd1;
            end
            n_pos = '0;
        end else if (r_pos < POS_MAX) begin
            n_pos          = r_pos + PW'(1);
            res.valid      = i_step && kept;
            res.field_code = code;
            res.char_pos   = r_pos[3:0];
            res.char_value = i_byte;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= HDR_WAIT;
            r_kind  <= KIND_NONE;
            r_comma <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_hdr   <= n_hdr;
            r_kind  <= n_kind;
            r_comma <= n_comma;
            r_pos   <= n_pos;
        end
    end

    a_dollar_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_byte == CH_DOLLAR) |=> (r_hdr == HDR_DOLLAR && r_kind == KIND_NONE))
        else $error("dollar did not restart header match");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("field position past saturation");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.sentence_end) |->
            (o_res.field_code == FC_TIME && o_res.char_pos == 4'd0 && o_res.char_value == 8'd0))
        else $error("end marker carries data");

    a_emit_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (i_step && r_hdr == HDR_BODY && r_kind != KIND_NONE))
        else $error("result outside a recognized sentence body");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.sentence_end) |-> (o_res.field_code <= FC_ALT))
        else $error("field code out of range");

endmodule

`default_nettype wire
